>>> rtl/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants of the purge sequencer unit.
// ----------------------------------------------------------------------------
package psu_pkg;

	localparam int TIME_BITS_DEF    = 16;
	localparam int PURGE_MS_BITS    = 16;
	localparam int ERR_BITS         = 8;
	localparam int DEFAULT_PURGE_MS = 2000;

	// item opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// notice kinds
	localparam logic [1:0] NOTE_NONE = 2'd0;
	localparam logic [1:0] NOTE_END  = 2'd1;
	localparam logic [1:0] NOTE_ERR  = 2'd2;

	typedef enum logic [5:0] {
		PH_IDLE        = 6'b000001,
		PH_FILL_ON     = 6'b000010,
		PH_WAIT_FILLED = 6'b000100,
		PH_TIMING      = 6'b001000,
		PH_SEND_END    = 6'b010000,
		PH_SEND_ERR    = 6'b100000
	} phase_t;

	typedef struct packed {
		logic                     operation;
		logic [PURGE_MS_BITS-1:0] purge_time_ms;
		logic                     fill_active;
		logic                     heads_filled;
		logic [ERR_BITS-1:0]      fill_error;
		logic                     send_accepted;
	} item_t;

	// control state of the sequence
	typedef struct packed {
		phase_t              phase;
		logic                filling_was_on;
		logic                busy;
		logic                fill_req;
		logic                valve_open;
		logic [ERR_BITS-1:0] captured_error;
	} ctl_t;

	typedef struct packed {
		logic                start_accepted;
		logic                busy_res;
		logic                fill_request;
		logic                air_valve;
		logic [1:0]          notify_kind;
		logic [ERR_BITS-1:0] notify_error;
	} res_t;

endpackage

>>> rtl/purge_sequencer_unit.sv
// ----------------------------------------------------------------------------
// purge_sequencer_unit
// Purge sequencer: start, fill, timed air valve, notice handshake.
// ----------------------------------------------------------------------------
// Each item (a start request or a millisecond tick) yields one result item.
// An accepted item is held in the input register, then a single combinational
// step updates the sequence state and loads the result register, and one item
// is taken every cycle as long as results are taken. The result register is
// the only limit on throughput: when it holds an untaken result, the input
// register waits.
// ----------------------------------------------------------------------------
module purge_sequencer_unit #(
	parameter int TIME_BITS = psu_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               operation,
	input  logic [psu_pkg::PURGE_MS_BITS-1:0]  purge_time_ms,
	input  logic                               fill_active,
	input  logic                               heads_filled,
	input  logic [psu_pkg::ERR_BITS-1:0]       fill_error,
	input  logic                               send_accepted,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               start_accepted,
	output logic                               busy_res,
	output logic                               fill_request,
	output logic                               air_valve,
	output logic [1:0]                         notify_kind,
	output logic [psu_pkg::ERR_BITS-1:0]       notify_error
);
	import psu_pkg::*;

	localparam logic [31:0] DEF_MS = 32'(DEFAULT_PURGE_MS);

	item_t                item_s1;
	logic                 valid_s1;
	res_t                 res_s2;
	logic                 valid_s2;
	logic                 advance;

	ctl_t                 ctl_q;
	logic [TIME_BITS-1:0] stored_q;
	logic [TIME_BITS-1:0] remaining_q;

	ctl_t                 ctl_nxt;
	logic [TIME_BITS-1:0] stored_nxt;
	logic [TIME_BITS-1:0] remaining_nxt;
	res_t                 res_nxt;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.operation     <= operation;
			item_s1.purge_time_ms <= purge_time_ms;
			item_s1.fill_active   <= fill_active;
			item_s1.heads_filled  <= heads_filled;
			item_s1.fill_error    <= fill_error;
			item_s1.send_accepted <= send_accepted;
		end
	end

	psu_step #(
		.TIME_BITS(TIME_BITS)
	) u_step (
		.item          (item_s1),
		.ctl           (ctl_q),
		.stored_ms     (stored_q),
		.remaining_ms  (remaining_q),
		.ctl_nxt       (ctl_nxt),
		.stored_nxt    (stored_nxt),
		.remaining_nxt (remaining_nxt),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase          <= PH_IDLE;
			ctl_q.filling_was_on <= 1'b0;
			ctl_q.busy           <= 1'b0;
			ctl_q.fill_req       <= 1'b0;
			ctl_q.valve_open     <= 1'b0;
			ctl_q.captured_error <= '0;
			stored_q             <= DEF_MS[TIME_BITS-1:0];
			remaining_q          <= '0;
		end else if (advance) begin
			ctl_q       <= ctl_nxt;
			stored_q    <= stored_nxt;
			remaining_q <= remaining_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_nxt;
	end

	assign out_valid      = valid_s2;
	assign start_accepted = res_s2.start_accepted;
	assign busy_res       = res_s2.busy_res;
	assign fill_request   = res_s2.fill_request;
	assign air_valve      = res_s2.air_valve;
	assign notify_kind    = res_s2.notify_kind;
	assign notify_error   = res_s2.notify_error;

endmodule

>>> rtl/psu_step.sv
// ----------------------------------------------------------------------------
// psu_step
// One step of the purge sequence: next state and result for one item.
// ----------------------------------------------------------------------------
module psu_step #(
	parameter int TIME_BITS = psu_pkg::TIME_BITS_DEF
) (
	input  psu_pkg::item_t       item,
	input  psu_pkg::ctl_t        ctl,
	input  logic [TIME_BITS-1:0] stored_ms,
	input  logic [TIME_BITS-1:0] remaining_ms,
	output psu_pkg::ctl_t        ctl_nxt,
	output logic [TIME_BITS-1:0] stored_nxt,
	output logic [TIME_BITS-1:0] remaining_nxt,
	output psu_pkg::res_t        res
);
	import psu_pkg::*;

	logic [31:0]          ptime_ext;
	logic [TIME_BITS-1:0] rem_dec;
	logic                 started;
	logic [1:0]           kind;
	logic [ERR_BITS-1:0]  nerr;
	logic                 finish;

	assign ptime_ext = 32'(item.purge_time_ms);
	assign rem_dec   = (remaining_ms != '0) ? remaining_ms - TIME_BITS'(1) : remaining_ms;

	always_comb begin
		ctl_nxt       = ctl;
		stored_nxt    = stored_ms;
		remaining_nxt = remaining_ms;
		started       = 1'b0;
		kind          = NOTE_NONE;
		nerr          = '0;
		finish        = 1'b0;

		if (item.operation == OP_START) begin
			if (ctl.phase == PH_IDLE) begin
				stored_nxt    = ptime_ext[TIME_BITS-1:0];
				ctl_nxt.busy  = 1'b1;
				ctl_nxt.phase = PH_FILL_ON;
				started       = 1'b1;
			end
		end else begin
			unique case (ctl.phase)
				PH_IDLE: begin
				end
				PH_FILL_ON: begin
					ctl_nxt.filling_was_on = item.fill_active;
					if (!item.fill_active)
						ctl_nxt.fill_req = 1'b1;
					ctl_nxt.phase = PH_WAIT_FILLED;
				end
				PH_WAIT_FILLED: begin
					if (item.fill_error != '0) begin
						ctl_nxt.captured_error = item.fill_error;
						ctl_nxt.phase          = PH_SEND_ERR;
					end else if (item.heads_filled) begin
						remaining_nxt      = stored_ms;
						ctl_nxt.valve_open = 1'b1;
						ctl_nxt.phase      = PH_TIMING;
					end
				end
				PH_TIMING: begin
					remaining_nxt = rem_dec;
					// end notice goes out on the same tick the count runs out
					if (rem_dec == '0) begin
						ctl_nxt.valve_open = 1'b0;
						ctl_nxt.phase      = PH_SEND_END;
						kind               = NOTE_END;
						finish             = item.send_accepted;
					end
				end
				PH_SEND_END: begin
					kind   = NOTE_END;
					finish = item.send_accepted;
				end
				PH_SEND_ERR: begin
					kind   = NOTE_ERR;
					nerr   = ctl.captured_error;
					finish = item.send_accepted;
				end
				default: begin
					ctl_nxt.valve_open = 1'b0;
					ctl_nxt.phase      = PH_IDLE;
				end
			endcase

			if (finish) begin
				ctl_nxt.busy = 1'b0;
				if (!ctl.filling_was_on)
					ctl_nxt.fill_req = 1'b0;
				ctl_nxt.phase = PH_IDLE;
			end
		end

		res.start_accepted = started;
		res.busy_res       = ctl_nxt.busy;
		res.fill_request   = ctl_nxt.fill_req;
		res.air_valve      = ctl_nxt.valve_open;
		res.notify_kind    = kind;
		res.notify_error   = nerr;
	end

endmodule
